### rtl/core/cvpme_pkg.sv
// cvpme_pkg: shared types and fixed widths for the chain Viterbi Potts core.
// Item and result payload structs, relax-unit control struct.
// No dependencies.
package cvpme_pkg;

    localparam int COST_W = 32;
    localparam int IN_W   = 24;
    localparam int CFG_W  = 5;
    localparam logic [CFG_W-1:0] NUM_LABELS_RST = 5'd16;

    typedef struct packed {
        logic signed [IN_W-1:0] unary_cost;
        logic signed [IN_W-1:0] edge_cost;
        logic                   chain_end;
    } item_t;

    typedef struct packed {
        logic [5:0]               node_index;
        logic [4:0]               best_label;
        logic signed [COST_W-1:0] min_energy;
        logic                     last_result;
        logic                     overflow;
    } result_t;

    // Per-item mode for the relax datapath
    typedef struct packed {
        logic first_node;    // node 0: cost is the unary alone
        logic single_label;  // one label: stay only, no edge cost
    } relax_ctrl_t;

endpackage

### rtl/core/chain_viterbi_potts_min_energy_core.sv
// chain_viterbi_potts_min_energy_core: streaming min-sum Viterbi, chain, Potts edges.
// Top level: sequencer, cost and backpointer memories, min tracking, traceback.
// Depends on cvpme_pkg and cvpme_relax.
//
// Usage
//  - item channel (item_valid/item_ready/item): one unary cost per transaction,
//    node by node, label 0 first; edge_cost is taken on the label-0 transaction.
//    chain_end marks the last transaction of the chain.
//  - result channel (result_valid/result_ready/result): after a chain end, one
//    transaction per node, last node first, each with the chain's minimum energy.
//  - cfg_we/cfg_wdata: labels per node; a write drops the chain in progress.
// Item and result flow
//  - each item runs through accept, memory read, move cost, pick and write
//    back; item_ready is high only between items, so the next item waits for
//    the cost-memory read-modify-write of one label. An item beyond node capacity
//    is dropped in its accept cycle.
//  - traceback: result_valid rises once the chain-end item is written back
//    (straight after its accept when the chain ran beyond capacity), then one
//    result per cycle while result_ready is high; the backpointer memory is read
//    one node ahead from the next-state address.
//  - no items are taken while results are being delivered.
// Reset clears counters and flags and sets the label count to 16; memories need no clear.
// A stalled receiver simply holds the current result; nothing is lost.
module chain_viterbi_potts_min_energy_core #(
    parameter int MAX_NODES  = 64,
    parameter int MAX_LABELS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  cvpme_pkg::item_t                    item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output cvpme_pkg::result_t                  result,
    input  logic                                cfg_we,
    input  logic [cvpme_pkg::CFG_W-1:0]         cfg_wdata
);

    localparam int CW       = cvpme_pkg::COST_W;
    localparam int LW       = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
    localparam int NW       = $clog2(MAX_NODES + 1);
    localparam int NLW      = $clog2(MAX_LABELS + 1);
    localparam int CM_DEPTH = 2 ** (LW + 1);
    localparam int BP_DEPTH = (MAX_NODES > 1) ? (MAX_NODES - 1) * MAX_LABELS : 1;
    localparam int BAW      = (BP_DEPTH > 1) ? $clog2(BP_DEPTH) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MOVE  = 3'd1;
    localparam logic [2:0] ST_PICK  = 3'd2;
    localparam logic [2:0] ST_TRACK = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [NW-1:0] NODE_FULL = NW'(MAX_NODES);
    localparam logic [NW-1:0] NODE_LAST = NW'(MAX_NODES - 1);

    // control state
    logic [2:0]                 state_reg, state_next;
    logic [cvpme_pkg::CFG_W-1:0] num_labels_reg, num_labels_next;
    logic [LW-1:0]              lab_cnt_reg, lab_cnt_next;
    logic [NW-1:0]              node_cnt_reg, node_cnt_next;
    logic                       overflow_reg, overflow_next;
    logic                       cur_bank_reg, cur_bank_next;
    logic                       end_reg, end_next;
    logic signed [cvpme_pkg::IN_W-1:0] edge_reg, edge_next;
    logic signed [cvpme_pkg::IN_W-1:0] unary_reg, unary_next;

    // min tracking: previous node (p), current node (c), first-lowest (f)
    logic [LW-1:0]        pmin_lab_reg, pmin_lab_next, psec_lab_reg, psec_lab_next;
    logic [LW-1:0]        cmin_lab_reg, cmin_lab_next, csec_lab_reg, csec_lab_next;
    logic [LW-1:0]        fmin_lab_reg, fmin_lab_next;
    logic signed [CW-1:0] pmin_val_reg, pmin_val_next, psec_val_reg, psec_val_next;
    logic signed [CW-1:0] cmin_val_reg, cmin_val_next, csec_val_reg, csec_val_next;
    logic signed [CW-1:0] fmin_val_reg, fmin_val_next;

    // traceback
    logic [NW-1:0] bt_node_reg, bt_node_next;
    logic [LW-1:0] bt_lab_reg, bt_lab_next;

    // memories
    logic signed [CW-1:0] cost_mem [CM_DEPTH];
    logic signed [CW-1:0] cost_rd_reg;
    logic [LW-1:0]        bp_mem [BP_DEPTH];
    logic [LW-1:0]        bp_rd_reg;
    logic [LW:0]          cost_waddr, cost_raddr;
    logic [BAW-1:0]       bp_waddr, bp_raddr;
    logic                 cost_we, bp_we;
    logic [LW-1:0]        bp_wdata;

    logic [NLW-1:0]       nl_used;
    logic                 node_full, last_label;
    logic [LW-1:0]        mv_lab;
    logic signed [CW-1:0] mv_cost;
    cvpme_pkg::relax_ctrl_t relax_ctrl;
    logic signed [CW-1:0] relax_cost;
    logic                 relax_took_move;
    logic signed [CW-1:0] c_new;

    // labels in use: 0 reads as 1, above capacity reads as capacity
    always_comb
    begin
        priority if (num_labels_reg == '0)
        begin
            nl_used = NLW'(1);
        end
        else if (32'(num_labels_reg) > MAX_LABELS)
        begin
            nl_used = NLW'(MAX_LABELS);
        end
        else
        begin
            nl_used = NLW'(num_labels_reg);
        end
    end

    assign node_full  = (node_cnt_reg == NODE_FULL);
    assign last_label = (8'(lab_cnt_reg) + 8'd1 >= 8'(nl_used));
    assign mv_lab     = (lab_cnt_reg != pmin_lab_reg) ? pmin_lab_reg : psec_lab_reg;
    assign mv_cost    = (lab_cnt_reg != pmin_lab_reg) ? pmin_val_reg : psec_val_reg;

    assign relax_ctrl.first_node   = (node_cnt_reg == '0);
    assign relax_ctrl.single_label = (nl_used == NLW'(1));

    cvpme_relax u_relax (
        .clk        (clk),
        .load_move  (state_reg == ST_MOVE),
        .load_pick  (state_reg == ST_PICK),
        .ctrl       (relax_ctrl),
        .stay_cost  (cost_rd_reg),
        .move_base  (mv_cost),
        .edge_cost  (edge_reg),
        .unary_cost (unary_reg),
        .new_cost   (relax_cost),
        .took_move  (relax_took_move)
    );

    assign c_new = relax_cost;

    always_comb
    begin
        state_next      = state_reg;
        num_labels_next = num_labels_reg;
        lab_cnt_next    = lab_cnt_reg;
        node_cnt_next   = node_cnt_reg;
        overflow_next   = overflow_reg;
        cur_bank_next   = cur_bank_reg;
        end_next        = end_reg;
        edge_next       = edge_reg;
        unary_next      = unary_reg;
        pmin_lab_next   = pmin_lab_reg;
        psec_lab_next   = psec_lab_reg;
        cmin_lab_next   = cmin_lab_reg;
        csec_lab_next   = csec_lab_reg;
        fmin_lab_next   = fmin_lab_reg;
        pmin_val_next   = pmin_val_reg;
        psec_val_next   = psec_val_reg;
        cmin_val_next   = cmin_val_reg;
        csec_val_next   = csec_val_reg;
        fmin_val_next   = fmin_val_reg;
        bt_node_next    = bt_node_reg;
        bt_lab_next     = bt_lab_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    unary_next = item.unary_cost;
                    end_next   = item.chain_end;
                    if (node_full)
                    begin
                        // beyond capacity: item dropped, flag raised
                        overflow_next = 1'b1;
                        if (item.chain_end)
                        begin
                            state_next   = ST_OUT;
                            bt_node_next = NODE_LAST;
                            bt_lab_next  = fmin_lab_reg;
                        end
                    end
                    else
                    begin
                        if (lab_cnt_reg == '0)
                        begin
                            edge_next = item.edge_cost;
                        end
                        state_next = ST_MOVE;
                    end
                end
            end
            ST_MOVE:
            begin
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                state_next = ST_TRACK;
            end
            ST_TRACK:
            begin
                // lowest-numbered minimum for the final pick
                if (lab_cnt_reg == '0 || c_new < fmin_val_reg)
                begin
                    fmin_lab_next = lab_cnt_reg;
                    fmin_val_next = c_new;
                end
                // min / second-min for the next node's moves
                priority if (lab_cnt_reg == '0)
                begin
                    cmin_lab_next = lab_cnt_reg;
                    cmin_val_next = c_new;
                end
                else if (lab_cnt_reg == LW'(1))
                begin
                    if (cmin_val_reg < c_new)
                    begin
                        csec_lab_next = lab_cnt_reg;
                        csec_val_next = c_new;
                    end
                    else
                    begin
                        csec_lab_next = cmin_lab_reg;
                        csec_val_next = cmin_val_reg;
                        cmin_lab_next = lab_cnt_reg;
                        cmin_val_next = c_new;
                    end
                end
                else if (c_new < cmin_val_reg)
                begin
                    csec_lab_next = cmin_lab_reg;
                    csec_val_next = cmin_val_reg;
                    cmin_lab_next = lab_cnt_reg;
                    cmin_val_next = c_new;
                end
                else if (c_new < csec_val_reg)
                begin
                    csec_lab_next = lab_cnt_reg;
                    csec_val_next = c_new;
                end

                if (end_reg)
                begin
                    state_next   = ST_OUT;
                    bt_node_next = node_cnt_reg;
                    bt_lab_next  = fmin_lab_next;
                end
                else
                begin
                    state_next = ST_IDLE;
                    if (last_label)
                    begin
                        // node complete: swap cost banks
                        cur_bank_next = ~cur_bank_reg;
                        pmin_lab_next = cmin_lab_next;
                        pmin_val_next = cmin_val_next;
                        psec_lab_next = csec_lab_next;
                        psec_val_next = csec_val_next;
                        lab_cnt_next  = '0;
                        node_cnt_next = node_cnt_reg + NW'(1);
                    end
                    else
                    begin
                        lab_cnt_next = lab_cnt_reg + LW'(1);
                    end
                end
            end
            ST_OUT:
            begin
                if (result_ready)
                begin
                    if (bt_node_reg == '0)
                    begin
                        state_next    = ST_IDLE;
                        lab_cnt_next  = '0;
                        node_cnt_next = '0;
                        overflow_next = 1'b0;
                    end
                    else
                    begin
                        bt_node_next = bt_node_reg - NW'(1);
                        bt_lab_next  = bp_rd_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            num_labels_next = cfg_wdata;
            lab_cnt_next    = '0;
            node_cnt_next   = '0;
            overflow_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            num_labels_reg <= cvpme_pkg::NUM_LABELS_RST;
            lab_cnt_reg    <= '0;
            node_cnt_reg   <= '0;
            overflow_reg   <= 1'b0;
            cur_bank_reg   <= 1'b0;
            end_reg        <= 1'b0;
            edge_reg       <= '0;
            pmin_lab_reg   <= '0;
            psec_lab_reg   <= '0;
            cmin_lab_reg   <= '0;
            csec_lab_reg   <= '0;
            fmin_lab_reg   <= '0;
            bt_node_reg    <= '0;
            bt_lab_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            num_labels_reg <= num_labels_next;
            lab_cnt_reg    <= lab_cnt_next;
            node_cnt_reg   <= node_cnt_next;
            overflow_reg   <= overflow_next;
            cur_bank_reg   <= cur_bank_next;
            end_reg        <= end_next;
            edge_reg       <= edge_next;
            pmin_lab_reg   <= pmin_lab_next;
            psec_lab_reg   <= psec_lab_next;
            cmin_lab_reg   <= cmin_lab_next;
            csec_lab_reg   <= csec_lab_next;
            fmin_lab_reg   <= fmin_lab_next;
            bt_node_reg    <= bt_node_next;
            bt_lab_reg     <= bt_lab_next;
        end
    end

    // cost payload, no reset
    always_ff @(posedge clk)
    begin
        unary_reg    <= unary_next;
        pmin_val_reg <= pmin_val_next;
        psec_val_reg <= psec_val_next;
        cmin_val_reg <= cmin_val_next;
        csec_val_reg <= csec_val_next;
        fmin_val_reg <= fmin_val_next;
    end

    // Cost memory: two banks, current node written, previous node read.
    // Read and write never hit the same entry; bank swap lands after the write.
    assign cost_we    = (state_reg == ST_TRACK);
    assign cost_waddr = {cur_bank_reg, lab_cnt_reg};
    assign cost_raddr = {~cur_bank_reg, lab_cnt_reg};

    always_ff @(posedge clk)
    begin
        if (cost_we)
        begin
            cost_mem[cost_waddr] <= relax_cost;
        end
        cost_rd_reg <= cost_mem[cost_raddr];
    end

    // Backpointer memory: row per node transition. Read address follows the
    // next traceback position so the data is ready when the result moves on.
    // The chain-end item's own entry is read in the cycle it is written, so
    // the write data is forwarded on a matching address.
    assign bp_we    = (state_reg == ST_TRACK) && (node_cnt_reg != '0);
    assign bp_wdata = relax_took_move ? mv_lab : lab_cnt_reg;
    assign bp_waddr = BAW'((32'(node_cnt_reg) - 1) * MAX_LABELS + 32'(lab_cnt_reg));
    assign bp_raddr = BAW'((32'(bt_node_next) - 1) * MAX_LABELS + 32'(bt_lab_next));

    always_ff @(posedge clk)
    begin
        if (bp_we)
        begin
            bp_mem[bp_waddr] <= bp_wdata;
        end
        if (bp_we && (bp_raddr == bp_waddr))
        begin
            bp_rd_reg <= bp_wdata;
        end
        else
        begin
            bp_rd_reg <= bp_mem[bp_raddr];
        end
    end

    // ports
    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = (state_reg == ST_OUT);

    assign result.node_index  = 6'(bt_node_reg);
    assign result.best_label  = 5'(32'(bt_lab_reg) + 1);
    assign result.min_energy  = fmin_val_reg;
    assign result.last_result = (bt_node_reg == '0);
    assign result.overflow    = overflow_reg;

    // checks
    a_no_overlap : assert property (@(posedge clk) disable iff (!rst_n)
        !(item_ready && result_valid))
        else $error("item accepted during traceback");

    a_trace_step : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !result.last_result
        |=> result_valid && (result.node_index == 6'($past(result.node_index) - 6'd1)))
        else $error("traceback did not step to the previous node");

    a_energy_hold : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !result.last_result |=> $stable(result.min_energy))
        else $error("min energy changed within a chain");

    a_back_idle : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && result.last_result |=> item_ready)
        else $error("block not ready after final result");

endmodule

### rtl/core/cvpme_relax.sv
// cvpme_relax: two-stage saturating min-sum relax step for one label.
// Stage 1 forms the move cost, stage 2 picks stay/move and adds the unary (node 0: unary alone).
// Depends on cvpme_pkg.
module cvpme_relax (
    input  logic                                  clk,
    input  logic                                  load_move,
    input  logic                                  load_pick,
    input  cvpme_pkg::relax_ctrl_t                ctrl,
    input  logic signed [cvpme_pkg::COST_W-1:0]   stay_cost,
    input  logic signed [cvpme_pkg::COST_W-1:0]   move_base,
    input  logic signed [cvpme_pkg::IN_W-1:0]     edge_cost,
    input  logic signed [cvpme_pkg::IN_W-1:0]     unary_cost,
    output logic signed [cvpme_pkg::COST_W-1:0]   new_cost,
    output logic                                  took_move
);

    localparam int CW = cvpme_pkg::COST_W;

    function automatic logic signed [CW-1:0] sat32(input logic signed [CW:0] v);
        logic signed [CW-1:0] r;
        if (v[CW] != v[CW-1])
        begin
            r = v[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end
        else
        begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    logic signed [CW-1:0]             stay_reg;
    logic signed [CW-1:0]             move_reg, move_next;
    logic signed [cvpme_pkg::IN_W-1:0] unary_reg;
    cvpme_pkg::relax_ctrl_t           ctrl_reg;
    logic signed [CW-1:0]             cost_reg, cost_next;
    logic                             took_reg, took_next;
    logic signed [CW-1:0]             pick;

    assign move_next = sat32((CW+1)'(move_base) + (CW+1)'(edge_cost));

    always_comb
    begin
        pick      = stay_reg;
        took_next = 1'b0;
        if (ctrl_reg.first_node)
        begin
            cost_next = CW'(unary_reg);
        end
        else
        begin
            // a tie goes to the move
            if (!ctrl_reg.single_label && !(stay_reg < move_reg))
            begin
                pick      = move_reg;
                took_next = 1'b1;
            end
            cost_next = sat32((CW+1)'(pick) + (CW+1)'(unary_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_move)
        begin
            stay_reg  <= stay_cost;
            move_reg  <= move_next;
            unary_reg <= unary_cost;
            ctrl_reg  <= ctrl;
        end
        if (load_pick)
        begin
            cost_reg <= cost_next;
            took_reg <= took_next;
        end
    end

    assign new_cost  = cost_reg;
    assign took_move = took_reg;

endmodule

### tb/sv/chain_viterbi_potts_min_energy_core_test.sv
`timescale 1ns / 1ps
// chain_viterbi_potts_min_energy_core_test: self-checking bench for the chain Viterbi core.
// Holds a scoreboard class with its own min-sum predictor; depends on cvpme_pkg and
// chain_viterbi_potts_min_energy_core.
module chain_viterbi_potts_min_energy_core_test;

    localparam int NODE_CAP     = 64;
    localparam int LABEL_CAP    = 16;
    localparam int SETTLE       = 8;     // lets the last item retire, with margin
    localparam int TAIL         = 20;    // watch for stray results after the last one
    localparam int IDLE_LIMIT   = 3000;  // cycles with no transaction on either channel
    localparam int LONG_HOLD    = 300;   // receiver back-pressure stretch
    localparam int RANDOM_ITEMS = 40;
    localparam int PRINT_CAP    = 100;

    localparam logic signed [cvpme_pkg::IN_W-1:0] COST_HI = 24'sh7FFFFF;
    localparam logic signed [cvpme_pkg::IN_W-1:0] COST_LO = 24'sh800000;
    localparam longint SUM_MAX = (longint'(1) <<< 31) - 1;
    localparam longint SUM_MIN = -(longint'(1) <<< 31);

    // Predictor and store of expected traceback results.
    class energy_scoreboard;
        int signed                   prev_cost [LABEL_CAP];
        int signed                   cur_cost  [LABEL_CAP];
        logic [3:0]                  back_ptr  [NODE_CAP * LABEL_CAP];
        int unsigned                 min_lbl;
        int unsigned                 second_lbl;
        int unsigned                 label_pos;
        int unsigned                 node_pos;
        int signed                   edge_hold;
        bit                          overrun;
        logic [cvpme_pkg::CFG_W-1:0] labels_reg;
        cvpme_pkg::result_t          expected_q [$];
        int                          errors;

        function new();
            foreach (prev_cost[i])
            begin
                prev_cost[i] = 0;
                cur_cost[i]  = 0;
            end
            foreach (back_ptr[i])
                back_ptr[i] = '0;
            min_lbl    = 0;
            second_lbl = 0;
            edge_hold  = 0;
            labels_reg = cvpme_pkg::NUM_LABELS_RST;
            errors     = 0;
            clear_chain();
        endfunction

        function void clear_chain();
            label_pos = 0;
            node_pos  = 0;
            overrun   = 1'b0;
        endfunction

        function void set_labels(logic [cvpme_pkg::CFG_W-1:0] value);
            labels_reg = value;
            clear_chain();
        endfunction

        function int unsigned labels_in_use();
            if (labels_reg == 0)
                return 1;
            if (labels_reg > LABEL_CAP)
                return LABEL_CAP;
            return labels_reg;
        endfunction

        function int signed sat_add(int signed a, int signed b);
            longint s;
            s = longint'(a) + longint'(b);
            if (s > SUM_MAX)
                return int'(SUM_MAX);
            if (s < SUM_MIN)
                return int'(SUM_MIN);
            return int'(s);
        endfunction

        // Cheapest and runner-up of the completed node; ties keep the earlier, but 1 beats 0.
        function void rank_labels(int unsigned nl);
            if (nl < 2)
            begin
                min_lbl    = 0;
                second_lbl = 0;
                return;
            end
            if (prev_cost[0] < prev_cost[1])
            begin
                min_lbl    = 0;
                second_lbl = 1;
            end
            else
            begin
                min_lbl    = 1;
                second_lbl = 0;
            end
            for (int unsigned l = 2; l < nl; l++)
            begin
                if (prev_cost[l] < prev_cost[min_lbl])
                begin
                    second_lbl = min_lbl;
                    min_lbl    = l;
                end
                else if (prev_cost[l] < prev_cost[second_lbl])
                    second_lbl = l;
            end
        endfunction

        function void note_item(cvpme_pkg::item_t it);
            int unsigned        nl;
            int unsigned        lab;
            int unsigned        mv;
            int unsigned        span;
            int unsigned        n;
            int signed          unary;
            int signed          stay;
            int signed          move;
            int signed          pick;
            int signed          energy;
            int signed          fin [LABEL_CAP];
            cvpme_pkg::result_t r;

            nl    = labels_in_use();
            unary = $signed(it.unary_cost);
            if (label_pos >= nl)
                label_pos = nl - 1;

            if (node_pos >= NODE_CAP)
                overrun = 1'b1;
            else
            begin
                lab = label_pos;
                if (lab == 0)
                    edge_hold = $signed(it.edge_cost);
                if (node_pos == 0)
                    cur_cost[lab] = unary;
                else if (nl == 1)
                begin
                    cur_cost[0] = sat_add(prev_cost[0], unary);
                    back_ptr[(node_pos - 1) * LABEL_CAP] = '0;
                end
                else
                begin
                    mv   = (lab != min_lbl) ? min_lbl : second_lbl;
                    stay = prev_cost[lab];
                    move = sat_add(prev_cost[mv], edge_hold);
                    // a tie goes to the move
                    if (stay < move)
                    begin
                        pick = stay;
                        back_ptr[(node_pos - 1) * LABEL_CAP + lab] = 4'(lab);
                    end
                    else
                    begin
                        pick = move;
                        back_ptr[(node_pos - 1) * LABEL_CAP + lab] = 4'(mv);
                    end
                    cur_cost[lab] = sat_add(pick, unary);
                end
                if (!it.chain_end)
                begin
                    if (lab + 1 >= nl)
                    begin
                        prev_cost = cur_cost;
                        rank_labels(nl);
                        label_pos = 0;
                        node_pos++;
                    end
                    else
                        label_pos = lab + 1;
                end
            end

            if (!it.chain_end)
                return;

            // Overrun chains report the first NODE_CAP nodes, all complete.
            if (node_pos >= NODE_CAP)
            begin
                fin  = prev_cost;
                span = nl;
                n    = NODE_CAP - 1;
            end
            else
            begin
                fin  = cur_cost;
                span = label_pos + 1;
                n    = node_pos;
            end

            lab    = 0;
            energy = fin[0];
            for (int unsigned l = 1; l < span; l++)
            begin
                if (fin[l] < energy)
                begin
                    lab    = l;
                    energy = fin[l];
                end
            end

            n++;
            do
            begin
                n--;
                r.node_index  = 6'(n);
                r.best_label  = 5'(lab + 1);
                r.min_energy  = energy;
                r.last_result = (n == 0);
                r.overflow    = overrun;
                expected_q.push_back(r);
                if (n != 0)
                    lab = back_ptr[(n - 1) * LABEL_CAP + (lab % LABEL_CAP)];
            end
            while (n != 0);

            clear_chain();
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            if (errors <= PRINT_CAP)
                $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        endtask

        task check_result(cvpme_pkg::result_t got);
            cvpme_pkg::result_t want;
            if (expected_q.size() == 0)
            begin
                report("result with none outstanding, node_index", got.node_index, -1);
                return;
            end
            want = expected_q.pop_front();
            if (got.node_index !== want.node_index)
                report("node_index", got.node_index, want.node_index);
            if (got.best_label !== want.best_label)
                report("best_label", got.best_label, want.best_label);
            if (got.min_energy !== want.min_energy)
                report("min_energy", got.min_energy, want.min_energy);
            if (got.last_result !== want.last_result)
                report("last_result", got.last_result, want.last_result);
            if (got.overflow !== want.overflow)
                report("overflow", got.overflow, want.overflow);
        endtask
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        item_valid;
    logic                        item_ready;
    cvpme_pkg::item_t            item;
    logic                        result_valid;
    logic                        result_ready;
    cvpme_pkg::result_t          result;
    logic                        cfg_we;
    logic [cvpme_pkg::CFG_W-1:0] cfg_wdata;

    energy_scoreboard sb;
    bit               hold_off_req;  // asks the result side for one long stall
    bit               arm_hold;      // raise hold_off_req on the next chain end
    bit               steady;        // sender offers back to back
    int unsigned      stream_items;

    chain_viterbi_potts_min_energy_core #(
        .MAX_NODES  (NODE_CAP),
        .MAX_LABELS (LABEL_CAP)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly no gap, some short ones, a few long ones, none in steady stretches.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 2)
            return $urandom_range(8, 40);
        if (r < 9)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    function automatic int unsigned pick_stall();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return $urandom_range(10, 40);
        if (r < 7)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    // Full range, extremes, and narrow bands so that ties turn up often.
    function automatic logic signed [cvpme_pkg::IN_W-1:0] rand_cost();
        int v;
        case ($urandom_range(0, 4))
            0:       v = int'($urandom_range(0, 16)) - 8;
            1:       v = $urandom_range(0, 1) ? int'(COST_HI) : int'(COST_LO);
            2:       v = int'($urandom_range(0, 2000)) - 1000;
            default: v = $urandom;
        endcase
        return cvpme_pkg::IN_W'(v);
    endfunction

    function automatic cvpme_pkg::item_t cost_item(logic signed [cvpme_pkg::IN_W-1:0] unary,
                                                   logic signed [cvpme_pkg::IN_W-1:0] potts,
                                                   bit last);
        cvpme_pkg::item_t it;
        it.unary_cost = unary;
        it.edge_cost  = potts;
        it.chain_end  = last;
        return it;
    endfunction

    // Offers one transaction and holds it until taken; valid stays high when no gap follows.
    task automatic push_item(cvpme_pkg::item_t it);
        int unsigned gap;
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sb.note_item(it);
        gap = pick_gap();
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_stream(int unsigned count, bit finish);
        cvpme_pkg::item_t it;
        for (int unsigned k = 1; k <= count; k++)
        begin
            it.unary_cost = rand_cost();
            it.edge_cost  = rand_cost();
            it.chain_end  = finish && (k == count);
            if (arm_hold && it.chain_end)
            begin
                hold_off_req = 1'b1;
                arm_hold     = 1'b0;
            end
            push_item(it);
        end
        stream_items += count;
    endtask

    // Label count is only changed with the block idle: results drained, last item retired.
    task automatic write_labels(logic [cvpme_pkg::CFG_W-1:0] value);
        item_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_labels(value);
    endtask

    // Result side: random stalls, calm stretches, and one long hold on request.
    initial
    begin : result_sink
        int unsigned stall_left;
        int unsigned hold_left;
        bit          calm;
        stall_left = 0;
        hold_left  = 0;
        calm       = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
                sb.check_result(result);
            if ($urandom_range(0, 99) == 0)
                calm = !calm;
            if (hold_left != 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left    = LONG_HOLD - 1;
                result_ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                if (!calm)
                    stall_left = pick_stall();
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned                 nl;
        int unsigned                 nodes;
        int unsigned                 total;
        int unsigned                 chains;
        int unsigned                 phase;
        bit                          dropped;
        logic [cvpme_pkg::CFG_W-1:0] value;

        sb           = new();
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_ready = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        hold_off_req = 1'b0;
        arm_hold     = 1'b0;
        steady       = 1'b0;
        stream_items = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset label count, chain ends on its very first transaction.
        push_item(cost_item(COST_LO, COST_HI, 1'b1));

        // Two labels, field extremes; node 2 latches the largest edge cost.
        write_labels(5'd2);
        push_item(cost_item(COST_HI, COST_LO, 1'b0));
        push_item(cost_item(COST_HI, 24'sd0, 1'b0));
        push_item(cost_item(COST_LO, COST_LO, 1'b0));
        push_item(cost_item(24'sd0, COST_HI, 1'b0));
        push_item(cost_item(24'sd0, COST_HI, 1'b0));
        push_item(cost_item(24'sd0, 24'sd0, 1'b1));

        // Three labels, equal costs: stay and move tie; chain ends part-way through node 1.
        write_labels(5'd3);
        push_item(cost_item(24'sd5, 24'sd0, 1'b0));
        push_item(cost_item(24'sd5, 24'sd0, 1'b0));
        push_item(cost_item(24'sd5, 24'sd0, 1'b0));
        push_item(cost_item(24'sd0, 24'sd0, 1'b0));
        push_item(cost_item(24'sd0, 24'sd0, 1'b1));

        // Zero is taken as one label: plain accumulation, edge cost unused.
        write_labels(5'd0);
        push_item(cost_item(COST_HI, COST_LO, 1'b0));
        push_item(cost_item(COST_HI, COST_LO, 1'b0));
        push_item(cost_item(COST_LO, COST_HI, 1'b1));

        // Chain dropped by a label-count write; 31 is clipped to the full 16.
        write_labels(5'd1);
        push_item(cost_item(24'sd7, 24'sd0, 1'b0));
        push_item(cost_item(-24'sd7, 24'sd0, 1'b0));
        write_labels(5'd31);

        // End inside node 0 with a tie for the cheapest label: lowest number wins.
        push_item(cost_item(24'sd3, 24'sd0, 1'b0));
        push_item(cost_item(24'sd1, 24'sd0, 1'b0));
        push_item(cost_item(-24'sd1, 24'sd0, 1'b0));
        push_item(cost_item(-24'sd1, 24'sd0, 1'b1));

        // Random chains; each phase drains results, then picks a new label count.
        // Chains are trimmed to the item budget (at least two items); the hold phase always runs.
        stream_items = 0;
        phase        = 0;
        while (stream_items < RANDOM_ITEMS || phase < 2)
        begin
            case ($urandom_range(0, 5))
                0:       value = 5'd1;
                1:       value = 5'd16;
                2:       value = $urandom_range(0, 1) ? 5'd0 : 5'd31;
                default: value = 5'($urandom_range(0, 31));
            endcase
            write_labels(value);
            nl = sb.labels_in_use();
            // phase 1: receiver holds off at the first chain end while more chains queue up
            if (phase == 1)
                arm_hold = 1'b1;
            chains  = (phase == 1) ? 3 : $urandom_range(1, 3);
            dropped = 1'b0;
            for (int c = 0; c < chains && !dropped; c++)
            begin
                steady = ($urandom_range(0, 3) == 0);
                if (nl <= 4 && $urandom_range(0, 4) == 0)
                    nodes = $urandom_range(6, 24);
                else
                    nodes = $urandom_range(1, 4);
                total = nodes * nl;
                if ($urandom_range(0, 3) == 0)
                    total -= $urandom_range(0, nl - 1);
                if (stream_items + total > RANDOM_ITEMS)
                    total = (stream_items + 2 < RANDOM_ITEMS) ? RANDOM_ITEMS - stream_items : 2;
                if (phase != 1 && $urandom_range(0, 9) == 0)
                begin
                    send_stream($urandom_range(1, total), 1'b0);
                    dropped = 1'b1;
                end
                else
                    send_stream(total, 1'b1);
            end
            phase++;
        end

        // Capacity, one label: overrun by two nodes, then exactly full.
        steady = 1'b0;
        write_labels(5'd1);
        send_stream(NODE_CAP + 2, 1'b1);
        send_stream(NODE_CAP, 1'b1);

        item_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);

        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
rtl/core/cvpme_pkg.sv
rtl/core/cvpme_relax.sv
rtl/core/chain_viterbi_potts_min_energy_core.sv
tb/sv/chain_viterbi_potts_min_energy_core_test.sv
